// ===== design/bdqs_pkg.sv =====
package bdqs_pkg;

  localparam int KIND_W = 3;
  localparam int DATA_W = 32;
  localparam int STATUS_W = 2;
  localparam int POS_W = 6;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_SEARCH     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_LIST       = 3'd5;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic              push;
    logic              pop;
    logic              at_back;
    logic              walk;
    logic              listing;
    logic [DATA_W-1:0] value;
  } cmd_t;

endpackage

// ===== design/bdqs_if.sv =====
interface bdqs_req_if import bdqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [KIND_W-1:0]        kind;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output kind, output value, input ready);
  modport sink (input valid, input kind, input value, output ready);
endinterface

interface bdqs_rsp_if import bdqs_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [STATUS_W-1:0]      status;
  logic [POS_W-1:0]         position;
  logic signed [DATA_W-1:0] element;
  logic                     last;

  modport source (output valid, output status, output position, output element,
                  output last, input ready);
  modport sink (input valid, input status, input position, input element,
                input last, output ready);
endinterface

// ===== design/bdqs_front.sv =====
module bdqs_front import bdqs_pkg::*; (
  bdqs_req_if.sink req,
  output logic     cmd_valid,
  input  logic     cmd_ready,
  output cmd_t     cmd
);

  logic known;

  always_comb begin
    known = 1'b1;
    cmd.push = 1'b0;
    cmd.pop = 1'b0;
    cmd.at_back = 1'b0;
    cmd.walk = 1'b0;
    cmd.listing = 1'b0;
    cmd.value = req.value;
    case (req.kind)
      KIND_PUSH_FRONT: begin
        cmd.push = 1'b1;
      end
      KIND_PUSH_BACK: begin
        cmd.push = 1'b1;
        cmd.at_back = 1'b1;
      end
      KIND_POP_FRONT: begin
        cmd.pop = 1'b1;
      end
      KIND_POP_BACK: begin
        cmd.pop = 1'b1;
        cmd.at_back = 1'b1;
      end
      KIND_SEARCH: begin
        cmd.walk = 1'b1;
      end
      KIND_LIST: begin
        cmd.walk = 1'b1;
        cmd.listing = 1'b1;
      end
      default: begin
        known = 1'b0;
      end
    endcase
  end

  // unknown kinds are taken and dropped
  assign req.ready = cmd_ready;
  assign cmd_valid = req.valid && known;

endmodule

// ===== design/bdqs_cmd_fifo.sv =====
module bdqs_cmd_fifo import bdqs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  cmd_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output cmd_t rd_data
);

  cmd_t       slots [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] fill;
  logic       do_wr;
  logic       do_rd;

  assign wr_ready = (fill != 2'd2);
  assign rd_valid = (fill != 2'd0);
  assign rd_data = slots[rptr];
  assign do_wr = wr_valid && wr_ready;
  assign do_rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= 1'b0;
      rptr <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr <= ~wptr;
      end
      if (do_rd) begin
        rptr <= ~rptr;
      end
      case ({do_wr, do_rd})
        2'b10: fill <= fill + 2'd1;
        2'b01: fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

// ===== design/bdqs_back.sv =====
module bdqs_back import bdqs_pkg::*; #(
  parameter int DEPTH = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cmd_valid,
  output logic       cmd_ready,
  input  cmd_t       cmd,
  bdqs_rsp_if.source rsp
);

  localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data;
  logic [IW-1:0]     rd_addr;
  logic              rd_en;
  logic [IW-1:0]     wr_addr;
  logic              wr_en;

  logic              state;
  logic              state_next;
  logic [IW-1:0]     front;
  logic [IW-1:0]     front_next;
  logic [CW-1:0]     count;
  logic [CW-1:0]     count_next;
  logic [IW-1:0]     walk_idx;
  logic [IW-1:0]     walk_idx_next;
  logic [DATA_W-1:0] key;
  logic              listing;

  logic                rsp_valid;
  logic [STATUS_W-1:0] rsp_status;
  logic [POS_W-1:0]    rsp_position;
  logic [DATA_W-1:0]   rsp_element;
  logic                rsp_last;
  logic                load;
  logic [STATUS_W-1:0] load_status;
  logic [POS_W-1:0]    load_position;
  logic [DATA_W-1:0]   load_element;
  logic                load_last;

  logic          out_free;
  logic          full;
  logic          empty;
  logic [IW-1:0] front_inc;
  logic [IW-1:0] front_dec;
  logic [CW-1:0] walk_pos;
  logic          walk_end;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [IW-1:0] offs);
    logic [IW:0] sum;
    sum = {1'b0, base} + {1'b0, offs};
    if (sum >= (IW+1)'(DEPTH)) begin
      sum = sum - (IW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign out_free = !rsp_valid || rsp.ready;
  assign full = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign front_inc = (front == IW'(DEPTH - 1)) ? '0 : front + 1'b1;
  assign front_dec = (front == '0) ? IW'(DEPTH - 1) : front - 1'b1;
  assign walk_pos = CW'(walk_idx) + 1'b1;
  assign walk_end = (walk_pos == count);

  always_comb begin
    state_next = state;
    front_next = front;
    count_next = count;
    walk_idx_next = walk_idx;
    cmd_ready = 1'b0;
    wr_en = 1'b0;
    wr_addr = front_dec;
    rd_en = 1'b0;
    rd_addr = front;
    load = 1'b0;
    load_status = STATUS_OK;
    load_position = '0;
    load_element = '0;
    load_last = 1'b1;
    case (state)
      ST_IDLE: begin
        if (cmd_valid && out_free) begin
          cmd_ready = 1'b1;
          if (cmd.push) begin
            load = 1'b1;
            if (full) begin
              load_status = STATUS_FULL;
            end else begin
              wr_en = 1'b1;
              count_next = count + 1'b1;
              if (cmd.at_back) begin
                wr_addr = slot_of(front, IW'(count));
              end else begin
                front_next = front_dec;
              end
            end
          end else if (cmd.pop) begin
            load = 1'b1;
            if (empty) begin
              load_status = STATUS_EMPTY;
            end else begin
              count_next = count - 1'b1;
              if (!cmd.at_back) begin
                front_next = front_inc;
              end
            end
          end else if (empty) begin
            load = 1'b1;
            load_status = STATUS_EMPTY;
          end else begin
            rd_en = 1'b1;
            walk_idx_next = '0;
            state_next = ST_WALK;
          end
        end
      end
      ST_WALK: begin
        if (out_free) begin
          if (listing) begin
            load = 1'b1;
            load_position = POS_W'(walk_pos);
            load_element = rd_data;
            load_last = walk_end;
          end else if (rd_data == key) begin
            load = 1'b1;
            load_position = POS_W'(walk_pos);
          end else if (walk_end) begin
            load = 1'b1;
            load_status = STATUS_NOT_FOUND;
          end
          if (walk_end || (!listing && rd_data == key)) begin
            state_next = ST_IDLE;
          end else begin
            walk_idx_next = walk_idx + 1'b1;
            rd_en = 1'b1;
            rd_addr = slot_of(front, walk_idx + 1'b1);
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= cmd.value;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd.walk) begin
      key <= cmd.value;
      listing <= cmd.listing;
    end
    walk_idx <= walk_idx_next;
    if (load) begin
      rsp_status <= load_status;
      rsp_position <= load_position;
      rsp_element <= load_element;
      rsp_last <= load_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      front <= '0;
      count <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      if (load) begin
        rsp_valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  assign rsp.valid = rsp_valid;
  assign rsp.status = rsp_status;
  assign rsp.position = rsp_position;
  assign rsp.element = rsp_element;
  assign rsp.last = rsp_last;

endmodule

// ===== design/bounded_deque_with_search_unit.sv =====
// double-ended queue of signed 32-bit values in a ring of DEPTH entries
// req channel: kind (push front/back, pop front/back, search, list) and value
// rsp channel: status, position, element, last; one transfer per push, pop or
//   search, one per stored element for list or one if it is empty (last marks the final one)
// unknown kinds are taken and produce nothing
// a 2-entry command queue sits between the decoder and the executing back end
// push, pop and empty/full answers pass the command queue and output register
// search walks one entry per cycle from the front while the output register is
//   free, after a registered read of the front entry; the answer is loaded at
//   the matching entry, or after the last stored entry for not found
// list gives one element per cycle once started while the receiver keeps up,
//   the ring memory read sets this pace; push and pop keep the back end idle
// reset empties the deque (front and count cleared); memory contents are
//   not cleared and never read before being written
// when the receiver holds rsp ready low the result stays in the output
//   register, the walk pauses and req keeps being taken until the queue fills
module bounded_deque_with_search_unit import bdqs_pkg::*; #(
  parameter int DEPTH = 32
) (
  input logic      clk,
  input logic      rst,
  bdqs_req_if.sink req,
  bdqs_rsp_if.source rsp
);

  logic front_valid;
  logic front_ready;
  cmd_t front_cmd;
  logic back_valid;
  logic back_ready;
  cmd_t back_cmd;

  bdqs_front u_front (
    .req       (req),
    .cmd_valid (front_valid),
    .cmd_ready (front_ready),
    .cmd       (front_cmd)
  );

  bdqs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_cmd),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_cmd)
  );

  bdqs_back #(
    .DEPTH (DEPTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (back_valid),
    .cmd_ready (back_ready),
    .cmd       (back_cmd),
    .rsp       (rsp)
  );

endmodule
